[rtl/core/front_coded_string_decoder_macros.svh]
// Assertion helpers for the front-coded string decoder
`ifndef FRONT_CODED_STRING_DECODER_MACROS_SVH
`define FRONT_CODED_STRING_DECODER_MACROS_SVH

`ifndef SYNTHESIS

`define FCSD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fcsd: same-cycle check failed");

`define FCSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fcsd: next-cycle check failed");

`else

`define FCSD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)

`define FCSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

[rtl/core/fcsd_pkg.sv]
package fcsd_pkg;

    localparam int STRING_DEPTH = 512;
    localparam int ADDR_W       = $clog2(STRING_DEPTH);
    localparam int POS_W        = ADDR_W + 1;

    localparam int BYTE_W = 8;
    localparam int IDX_W  = 9;
    localparam int LEN_W  = 10;
    localparam int ACC_W  = 16;

    localparam int CMP_W  = (POS_W > IDX_W) ? POS_W : IDX_W;
    localparam int LEXT_W = (POS_W > LEN_W) ? POS_W : LEN_W;

    localparam int QUEUE_DEPTH = 2;

    // variable-byte length code
    localparam int               VB_STOP_BIT     = 7;
    localparam int               VB_SHIFT        = 7;
    localparam logic [6:0]       VB_PAYLOAD_MASK = 7'h7f;
    localparam logic [ACC_W-1:0] ACC_SAT         = 16'hffff;

    localparam logic ACT_FEED = 1'b0;
    localparam logic ACT_READ = 1'b1;

    typedef struct packed {
        logic              action;
        logic [BYTE_W-1:0] data_byte;
        logic [IDX_W-1:0]  read_index;
    } t_in;

    typedef struct packed {
        logic              entry_done;
        logic [LEN_W-1:0]  entry_length;
        logic [BYTE_W-1:0] char_out;
        logic              overflow;
    } t_out;

    typedef enum logic [2:0] {
        OP_NOP    = 3'd0,
        OP_PREFIX = 3'd1,
        OP_WRITE  = 3'd2,
        OP_DONE   = 3'd3,
        OP_READ   = 3'd4
    } t_op_kind;

    typedef struct packed {
        t_op_kind          kind;
        logic [POS_W-1:0]  pre;
        logic              pre_ovf;
        logic [BYTE_W-1:0] data;
        logic [IDX_W-1:0]  idx;
    } t_op;

endpackage

[rtl/core/front_coded_string_decoder.sv]
// channel   direction  handshake                 payload
// input     in         i_in_valid / o_in_ready   i_in_item  (fcsd_pkg::t_in)
// result    out        o_out_valid / i_out_ready o_out_item (fcsd_pkg::t_out)
//
// One transaction per cycle sustained while results are taken and the store is not
// being cleared; each result passes the queue register, then the store's read register.
// After reset the string store is zeroed, one entry a cycle: o_in_ready stays low
// until all STRING_DEPTH (512) entries are cleared.
// A stalled result holds the back end; the two-entry queue then fills and
// o_in_ready drops until the result is taken.
module front_coded_string_decoder (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  fcsd_pkg::t_in  i_in_item,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output fcsd_pkg::t_out o_out_item
);
    import fcsd_pkg::*;

    t_op  push_op, head_op;
    logic push, pop, q_valid, q_full, clearing;

    fcsd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_in_item (i_in_item),
        .i_q_full  (q_full),
        .i_clearing(clearing),
        .o_push    (push),
        .o_op      (push_op)
    );

    fcsd_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_op   (push_op),
        .i_pop  (pop),
        .o_head (head_op),
        .o_valid(q_valid),
        .o_full (q_full)
    );

    fcsd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op       (head_op),
        .i_q_valid  (q_valid),
        .o_pop      (pop),
        .o_clearing (clearing),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item (o_out_item)
    );

endmodule

[rtl/core/fcsd_ram.sv]
module fcsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/fcsd_front.sv]
`include "front_coded_string_decoder_macros.svh"

module fcsd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  fcsd_pkg::t_in i_in_item,
    input  logic          i_q_full,
    input  logic          i_clearing,
    output logic          o_push,
    output fcsd_pkg::t_op o_op
);
    import fcsd_pkg::*;

    logic             r_in_sfx, n_in_sfx;
    logic [ACC_W-1:0] r_acc, n_acc;
    logic [ACC_W-1:0] pre_full;
    logic             accept;

    assign o_in_ready = !i_q_full && !i_clearing;
    assign accept     = i_in_valid && o_in_ready;
    assign o_push     = accept;

    assign pre_full = r_acc | ACC_W'(i_in_item.data_byte & {1'b0, VB_PAYLOAD_MASK});

    always_comb begin
        n_in_sfx     = r_in_sfx;
        n_acc        = r_acc;
        o_op.kind    = OP_NOP;
        o_op.pre     = '0;
        o_op.pre_ovf = 1'b0;
        o_op.data    = i_in_item.data_byte;
        o_op.idx     = i_in_item.read_index;
        priority if (i_in_item.action == ACT_READ) begin
            o_op.kind = OP_READ;
        end else if (!r_in_sfx) begin
            if (!i_in_item.data_byte[VB_STOP_BIT]) begin
                if (r_acc > (ACC_SAT >> VB_SHIFT)) begin
                    n_acc = ACC_SAT;
                end else begin
                    n_acc = (r_acc | ACC_W'(i_in_item.data_byte)) << VB_SHIFT;
                end
            end else begin
                n_acc        = '0;
                n_in_sfx     = 1'b1;
                o_op.kind    = OP_PREFIX;
                o_op.pre_ovf = pre_full > ACC_W'(STRING_DEPTH);
                o_op.pre     = o_op.pre_ovf ? POS_W'(STRING_DEPTH) : pre_full[POS_W-1:0];
            end
        end else if (i_in_item.data_byte != '0) begin
            o_op.kind = OP_WRITE;
        end else begin
            o_op.kind = OP_DONE;
            n_in_sfx  = 1'b0;
            n_acc     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_sfx <= 1'b0;
            r_acc    <= '0;
        end else if (accept) begin
            r_in_sfx <= n_in_sfx;
            r_acc    <= n_acc;
        end
    end

    `FCSD_ASSERT_NEXT(a_prefix_enters_suffix, i_clk, i_rst_n, accept && o_op.kind == OP_PREFIX, r_in_sfx)
    `FCSD_ASSERT_NEXT(a_done_clears_length, i_clk, i_rst_n, accept && o_op.kind == OP_DONE, !r_in_sfx && r_acc == '0)

endmodule

[rtl/core/fcsd_queue.sv]
`include "front_coded_string_decoder_macros.svh"

module fcsd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  fcsd_pkg::t_op i_op,
    input  logic          i_pop,
    output fcsd_pkg::t_op o_head,
    output logic          o_valid,
    output logic          o_full
);
    import fcsd_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_op              r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    assign o_head  = r_mem[r_rd];
    assign o_valid = r_cnt != '0;
    assign o_full  = r_cnt == CNT_W'(QUEUE_DEPTH);

    always_comb begin
        unique case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + CNT_W'(1);
            2'b01:   n_cnt = r_cnt - CNT_W'(1);
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
        end
    end

    `FCSD_ASSERT_IMPL(a_no_push_when_full, i_clk, i_rst_n, i_push, !o_full)
    `FCSD_ASSERT_IMPL(a_no_pop_when_empty, i_clk, i_rst_n, i_pop, o_valid)

endmodule

[rtl/core/fcsd_back.sv]
`include "front_coded_string_decoder_macros.svh"

module fcsd_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  fcsd_pkg::t_op  i_op,
    input  logic           i_q_valid,
    output logic           o_pop,
    output logic           o_clearing,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output fcsd_pkg::t_out o_out_item
);
    import fcsd_pkg::*;

    logic              r_clr;
    logic [ADDR_W-1:0] r_clr_addr;
    logic [POS_W-1:0]  r_wpos, n_wpos;
    logic [POS_W-1:0]  r_len, n_len;
    logic              r_ovf, n_ovf;

    logic              r_pend_valid;
    logic              r_pend_done;
    logic [LEN_W-1:0]  r_pend_len;
    logic              r_pend_ovf;
    logic              r_pend_rd_ok;

    logic              fire;
    logic              done;
    logic              rd_ok;
    logic [CMP_W-1:0]  idx_ext;
    logic [CMP_W-1:0]  len_ext;
    logic [LEXT_W-1:0] len_out;

    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] ram_addr;
    logic [BYTE_W-1:0] ram_wdata, ram_q;

    assign fire       = i_q_valid && !r_clr && (!r_pend_valid || i_out_ready);
    assign o_pop      = fire;
    assign o_clearing = r_clr;

    assign idx_ext = CMP_W'(i_op.idx);
    assign len_ext = CMP_W'(r_len);
    assign len_out = LEXT_W'(n_len);

    always_comb begin
        n_wpos    = r_wpos;
        n_len     = r_len;
        n_ovf     = r_ovf;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_addr  = r_wpos[ADDR_W-1:0];
        ram_wdata = i_op.data;
        done      = 1'b0;
        rd_ok     = 1'b0;
        if (r_clr) begin
            ram_we    = 1'b1;
            ram_addr  = r_clr_addr;
            ram_wdata = '0;
        end else if (fire) begin
            unique case (i_op.kind)
                OP_NOP: begin
                end
                OP_PREFIX: begin
                    n_wpos = i_op.pre;
                    if (i_op.pre_ovf) begin
                        n_ovf = 1'b1;
                    end
                end
                OP_WRITE: begin
                    if (r_wpos < POS_W'(STRING_DEPTH)) begin
                        ram_we = 1'b1;
                        n_wpos = r_wpos + POS_W'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                end
                OP_DONE: begin
                    n_len = r_wpos;
                    done  = 1'b1;
                end
                OP_READ: begin
                    ram_re   = 1'b1;
                    ram_addr = idx_ext[ADDR_W-1:0];
                    rd_ok    = (idx_ext < len_ext) && (idx_ext < CMP_W'(STRING_DEPTH));
                end
                default: begin
                end
            endcase
        end
    end

    fcsd_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(STRING_DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_re   (ram_re),
        .i_addr (ram_addr),
        .i_wdata(ram_wdata),
        .o_rdata(ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr        <= 1'b1;
            r_clr_addr   <= '0;
            r_wpos       <= '0;
            r_len        <= '0;
            r_ovf        <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            if (r_clr) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
                if (r_clr_addr == ADDR_W'(STRING_DEPTH - 1)) begin
                    r_clr <= 1'b0;
                end
            end
            r_wpos <= n_wpos;
            r_len  <= n_len;
            r_ovf  <= n_ovf;
            if (fire) begin
                r_pend_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_pend_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_pend_done  <= done;
            r_pend_len   <= len_out[LEN_W-1:0];
            r_pend_ovf   <= n_ovf;
            r_pend_rd_ok <= rd_ok;
        end
    end

    assign o_out_valid             = r_pend_valid;
    assign o_out_item.entry_done   = r_pend_done;
    assign o_out_item.entry_length = r_pend_len;
    assign o_out_item.char_out     = r_pend_rd_ok ? ram_q : '0;
    assign o_out_item.overflow     = r_pend_ovf;

    `FCSD_ASSERT_IMPL(a_wpos_in_range, i_clk, i_rst_n, 1'b1, r_wpos <= POS_W'(STRING_DEPTH))
    `FCSD_ASSERT_IMPL(a_len_in_range, i_clk, i_rst_n, 1'b1, r_len <= POS_W'(STRING_DEPTH))
    `FCSD_ASSERT_IMPL(a_no_result_while_clearing, i_clk, i_rst_n, r_clr, !r_pend_valid)

endmodule
